// ----- design/drop_oldest_message_queue_core_macros.svh -----
// Assertion helpers shared by the queue RTL.
`ifndef DROP_OLDEST_MESSAGE_QUEUE_CORE_MACROS_SVH
`define DROP_OLDEST_MESSAGE_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DOQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define DOQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/doq_pkg.sv -----
`timescale 1ns / 1ps
package doq_pkg;
  localparam int SIZE_W    = 24;
  localparam int BYTE_W    = 28;
  localparam int MB_W      = 5;
  localparam int SAT_W     = 5;
  localparam int TOT_W     = 32;
  localparam int DEPTH_DEF = 16;

  localparam logic [BYTE_W-1:0] BYTE_BUDGET_RST = 28'd4194304;
  localparam logic [MB_W-1:0]   MSG_BUDGET_RST  = 5'd16;

  // configuration register indexes
  localparam logic CFG_BYTE_BUDGET = 1'b0;
  localparam logic CFG_MSG_BUDGET  = 1'b1;

  // command codes
  localparam logic CMD_ENQUEUE  = 1'b0;
  localparam logic CMD_PROGRESS = 1'b1;

  typedef struct packed {
    logic              ctrl;
    logic [SIZE_W-1:0] size;
  } entry_t;
endpackage

// ----- design/drop_oldest_message_queue_core.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    command, msg_size, is_control, bytes_written
// out      output     out_valid / out_ready  accepted .. total_sent
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is processed at a time: an enqueue that fits goes through S_ENQ and
// S_OUT, a progress word through S_PRG and S_OUT (S_OUT alone on an empty queue),
// an enqueue that must drop first compacts the entry memory, S_RD/S_EV per entry.
// Reset is synchronous; the entry memory needs no clearing.
// in_ready drops while a word is in flight; a result waiting on out_ready
// holds the last state until it can be loaded into the output register.
module drop_oldest_message_queue_core
  import doq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [SIZE_W-1:0] in_msg_size,
  input  logic              in_is_control,
  input  logic [SIZE_W-1:0] in_bytes_written,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_accepted,
  output logic              out_refused_full,
  output logic [SAT_W-1:0]  out_dropped_now,
  output logic              out_front_completed,
  output logic [SAT_W-1:0]  out_entry_count,
  output logic [BYTE_W-1:0] out_bytes_queued,
  output logic [TOT_W-1:0]  out_total_dropped,
  output logic [TOT_W-1:0]  out_total_sent,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_data
);
  `include "drop_oldest_message_queue_core_macros.svh"

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int DW  = CW + 1;
  localparam int BW  = (CW > MB_W) ? CW : MB_W;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_ENQ, S_PRG, S_OUT} state_t;

  state_t             state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic               ctrl_r, ctrl_nxt;
  logic [SIZE_W-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [BYTE_W-1:0]  byte_total_r, byte_total_nxt;
  logic [SIZE_W-1:0]  front_sent_r, front_sent_nxt;
  logic [TOT_W-1:0]   drop_cnt_r, drop_cnt_nxt;
  logic [TOT_W-1:0]   sent_cnt_r, sent_cnt_nxt;
  logic [BYTE_W-1:0]  byte_budget_r;
  logic [MB_W-1:0]    msg_budget_r;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      orig_cnt_r, orig_cnt_nxt;
  logic               start_r, start_nxt;
  logic [DW-1:0]      dropped_r, dropped_nxt;
  logic               acc_r, acc_nxt;
  logic               ref_r, ref_nxt;
  logic               comp_r, comp_nxt;

  logic               out_valid_r;
  logic               out_acc_r, out_ref_r, out_comp_r;
  logic [SAT_W-1:0]   out_drop_r, out_cnt_r;
  logic [BYTE_W-1:0]  out_bytes_r;
  logic [TOT_W-1:0]   out_tdrop_r, out_tsent_r;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  entry_t             mem_wdata, mem_rdata;

  logic [SIZE_W-1:0]  sz_sel;
  logic [BYTE_W:0]    sum_c;
  logic               over_c;
  logic [BW-1:0]      limit_c;
  logic [AW:0]        tail_sum;
  logic [AW-1:0]      tail_c;
  logic               in_fire, out_load;
  logic               drop_c;
  logic [SIZE_W-1:0]  rem_c, w_c, fs_c;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] sub_sat(input logic [BYTE_W-1:0] t,
                                                input logic [SIZE_W-1:0] n);
    logic [BYTE_W-1:0] ne;
    ne = BYTE_W'(n);
    return (ne > t) ? '0 : t - ne;
  endfunction

  doq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || out_ready;

  // budget check against the current totals
  assign sz_sel  = (state_r == S_IDLE) ? in_msg_size : size_r;
  assign sum_c   = {1'b0, byte_total_r} + (BYTE_W + 1)'(sz_sel);
  assign limit_c = (BW'(msg_budget_r) < BW'(DEPTH)) ? BW'(msg_budget_r) : BW'(DEPTH);
  assign over_c  = (sum_c > {1'b0, byte_budget_r}) || (BW'(count_r) >= limit_c);

  // tail slot behind the last entry
  assign tail_sum = {1'b0, head_r} + (AW + 1)'(count_r);
  assign tail_c   = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                    : AW'(tail_sum);

  // progress arithmetic on the front entry
  assign rem_c = (front_sent_r < mem_rdata.size) ? mem_rdata.size - front_sent_r : '0;
  assign w_c   = (wr_r > rem_c) ? rem_c : wr_r;
  assign fs_c  = front_sent_r + w_c;

  assign drop_c = ((k_r != '0) || !start_r) && !mem_rdata.ctrl && over_c;

  assign mem_raddr = (state_r == S_RD) ? rd_ptr_r : head_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    size_nxt       = size_r;
    ctrl_nxt       = ctrl_r;
    wr_nxt         = wr_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    byte_total_nxt = byte_total_r;
    front_sent_nxt = front_sent_r;
    drop_cnt_nxt   = drop_cnt_r;
    sent_cnt_nxt   = sent_cnt_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    k_nxt          = k_r;
    orig_cnt_nxt   = orig_cnt_r;
    start_nxt      = start_r;
    dropped_nxt    = dropped_r;
    acc_nxt        = acc_r;
    ref_nxt        = ref_r;
    comp_nxt       = comp_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_ptr_r;
    mem_wdata      = mem_rdata;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_command;
          size_nxt    = in_msg_size;
          ctrl_nxt    = in_is_control;
          wr_nxt      = in_bytes_written;
          dropped_nxt = '0;
          acc_nxt     = 1'b0;
          ref_nxt     = 1'b0;
          comp_nxt    = 1'b0;
          if (in_command == CMD_ENQUEUE) begin
            if ((count_r != '0) && over_c) begin
              // start a compaction pass from the front
              rd_ptr_nxt   = head_r;
              wr_ptr_nxt   = head_r;
              k_nxt        = '0;
              orig_cnt_nxt = count_r;
              start_nxt    = (front_sent_r != '0);
              state_nxt    = S_RD;
            end else begin
              state_nxt = S_ENQ;
            end
          end else begin
            state_nxt = (count_r != '0) ? S_PRG : S_OUT;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        // drop the entry or move it down to the write slot
        if (drop_c) begin
          byte_total_nxt = sub_sat(byte_total_r, mem_rdata.size);
          count_nxt      = count_r - 1'b1;
          dropped_nxt    = dropped_r + 1'b1;
          drop_cnt_nxt   = drop_cnt_r + 1'b1;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = wr_ptr_r;
          mem_wdata  = mem_rdata;
          wr_ptr_nxt = ptr_inc(wr_ptr_r);
        end
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        k_nxt      = k_r + 1'b1;
        state_nxt  = (k_r + 1'b1 == orig_cnt_r) ? S_ENQ : S_RD;
      end
      S_ENQ: begin
        if (over_c && !ctrl_r) begin
          dropped_nxt  = dropped_r + 1'b1;
          drop_cnt_nxt = drop_cnt_r + 1'b1;
        end else if (count_r >= CW'(DEPTH)) begin
          ref_nxt = 1'b1;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = tail_c;
          mem_wdata.ctrl = ctrl_r;
          mem_wdata.size = size_r;
          count_nxt      = count_r + 1'b1;
          byte_total_nxt = sum_c[BYTE_W] ? '1 : sum_c[BYTE_W-1:0];
          acc_nxt        = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_PRG: begin
        // advance the front offset, pop when complete
        if (fs_c >= mem_rdata.size) begin
          byte_total_nxt = sub_sat(byte_total_r, mem_rdata.size);
          head_nxt       = ptr_inc(head_r);
          count_nxt      = count_r - 1'b1;
          front_sent_nxt = '0;
          sent_cnt_nxt   = sent_cnt_r + 1'b1;
          comp_nxt       = 1'b1;
        end else begin
          front_sent_nxt = fs_c;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      byte_total_r  <= '0;
      front_sent_r  <= '0;
      drop_cnt_r    <= '0;
      sent_cnt_r    <= '0;
      byte_budget_r <= BYTE_BUDGET_RST;
      msg_budget_r  <= MSG_BUDGET_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      byte_total_r <= byte_total_nxt;
      front_sent_r <= front_sent_nxt;
      drop_cnt_r   <= drop_cnt_nxt;
      sent_cnt_r   <= sent_cnt_nxt;
      // take configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BYTE_BUDGET: byte_budget_r <= cfg_data;
          CFG_MSG_BUDGET:  msg_budget_r  <= cfg_data[MB_W-1:0];
          default: ;
        endcase
      end
      // load or release the output word
      if (state_r == S_OUT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    size_r     <= size_nxt;
    ctrl_r     <= ctrl_nxt;
    wr_r       <= wr_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    k_r        <= k_nxt;
    orig_cnt_r <= orig_cnt_nxt;
    start_r    <= start_nxt;
    dropped_r  <= dropped_nxt;
    acc_r      <= acc_nxt;
    ref_r      <= ref_nxt;
    comp_r     <= comp_nxt;
    if (state_r == S_OUT && out_load) begin
      out_acc_r   <= acc_r && (cmd_r == CMD_ENQUEUE);
      out_ref_r   <= ref_r;
      out_comp_r  <= comp_r;
      out_drop_r  <= (dropped_r > DW'(31)) ? 5'd31 : SAT_W'(dropped_r);
      out_cnt_r   <= ((CW + 1)'(count_r) > (CW + 1)'(31)) ? 5'd31 : SAT_W'(count_r);
      out_bytes_r <= byte_total_r;
      out_tdrop_r <= drop_cnt_r;
      out_tsent_r <= sent_cnt_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_refused_full    = out_ref_r;
  assign out_dropped_now     = out_drop_r;
  assign out_front_completed = out_comp_r;
  assign out_entry_count     = out_cnt_r;
  assign out_bytes_queued    = out_bytes_r;
  assign out_total_dropped   = out_tdrop_r;
  assign out_total_sent      = out_tsent_r;

  `DOQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `DOQ_ASSERT_IMP(a_acc_xor_ref, out_valid_r, !(out_acc_r && out_ref_r))
  `DOQ_ASSERT_IMP(a_sent_needs_entry, front_sent_r != '0, count_r != '0)
  `DOQ_ASSERT_NXT(a_busy_after_take, in_fire, state_r != S_IDLE)
endmodule

// ----- design/doq_mem.sv -----
`timescale 1ns / 1ps
module doq_mem
  import doq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ----- tb/sv/drop_oldest_message_queue_core_tb.sv -----
`timescale 1ns / 1ps
module drop_oldest_message_queue_core_tb;
  import doq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic              command;
    logic [SIZE_W-1:0] msg_size;
    logic              is_control;
    logic [SIZE_W-1:0] bytes_written;
  } word_t;

  typedef struct {
    logic              accepted;
    logic              refused_full;
    logic [SAT_W-1:0]  dropped_now;
    logic              front_completed;
    logic [SAT_W-1:0]  entry_count;
    logic [BYTE_W-1:0] bytes_queued;
    logic [TOT_W-1:0]  total_dropped;
    logic [TOT_W-1:0]  total_sent;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [SIZE_W-1:0] in_msg_size = '0;
  logic in_is_control = 1'b0;
  logic [SIZE_W-1:0] in_bytes_written = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted, out_refused_full, out_front_completed;
  logic [SAT_W-1:0] out_dropped_now, out_entry_count;
  logic [BYTE_W-1:0] out_bytes_queued;
  logic [TOT_W-1:0] out_total_dropped, out_total_sent;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_BYTE_BUDGET;
  logic [BYTE_W-1:0] cfg_data = '0;

  drop_oldest_message_queue_core dut (.*);

  always #2 clk = ~clk;

  // queue model state
  logic [SIZE_W-1:0] sizes_m[QDEPTH];
  logic              ctrl_m[QDEPTH];
  int unsigned       count_m;
  logic [BYTE_W-1:0] bytes_m;
  logic [SIZE_W-1:0] front_sent_m;
  logic [TOT_W-1:0]  dropped_m, sent_m;
  logic [BYTE_W-1:0] byte_budget_m;
  logic [MB_W-1:0]   msg_budget_m;

  word_t   pending_words[$];
  status_t expected_status[$];
  int errors = 0;
  bit hold_sender = 1'b0;
  longint cycles = 0;

  function automatic void remove_at(int unsigned idx);
    bytes_m = (sizes_m[idx] > bytes_m) ? '0 : bytes_m - sizes_m[idx];
    for (int unsigned i = idx; i + 1 < count_m; i++) begin
      sizes_m[i] = sizes_m[i+1];
      ctrl_m[i]  = ctrl_m[i+1];
    end
    count_m--;
  endfunction

  function automatic bit exceeds_budget(logic [SIZE_W-1:0] sz);
    int unsigned lim;
    lim = (msg_budget_m < QDEPTH) ? msg_budget_m : QDEPTH;
    return (longint'(bytes_m) + sz > longint'(byte_budget_m)) || (count_m + 1 > lim);
  endfunction

  function automatic status_t queue_step(word_t w);
    status_t s;
    int unsigned dropped, i;
    longint sum;
    logic [SIZE_W-1:0] wr, rem;
    s = '{default: '0};
    dropped = 0;
    if (w.command == CMD_ENQUEUE) begin
      // evict oldest droppable entries until the word fits
      while (count_m > 0 && exceeds_budget(w.msg_size)) begin
        i = (front_sent_m > 0) ? 1 : 0;
        while (i < count_m && ctrl_m[i]) i++;
        if (i >= count_m) break;
        remove_at(i);
        dropped++;
        dropped_m++;
      end
      if (exceeds_budget(w.msg_size) && !w.is_control) begin
        dropped++;
        dropped_m++;
      end else if (count_m >= QDEPTH) begin
        s.refused_full = 1'b1;
      end else begin
        sum = longint'(bytes_m) + w.msg_size;
        sizes_m[count_m] = w.msg_size;
        ctrl_m[count_m]  = w.is_control;
        count_m++;
        bytes_m = (sum > 64'h0FFFFFFF) ? 28'hFFFFFFF : sum[BYTE_W-1:0];
        s.accepted = 1'b1;
      end
    end else if (count_m > 0) begin
      // advance the front offset, pop when complete
      rem = (front_sent_m < sizes_m[0]) ? sizes_m[0] - front_sent_m : '0;
      wr = (w.bytes_written > rem) ? rem : w.bytes_written;
      front_sent_m += wr;
      if (front_sent_m >= sizes_m[0]) begin
        remove_at(0);
        front_sent_m = '0;
        sent_m++;
        s.front_completed = 1'b1;
      end
    end
    s.dropped_now     = (dropped > 31) ? 5'd31 : dropped[SAT_W-1:0];
    s.entry_count     = count_m[SAT_W-1:0];
    s.bytes_queued    = bytes_m;
    s.total_dropped   = dropped_m;
    s.total_sent      = sent_m;
    return s;
  endfunction

  function automatic void queue_word(word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic word_t enq(int unsigned sz, bit ctl);
    word_t w;
    w.command = CMD_ENQUEUE;
    w.msg_size = sz[SIZE_W-1:0];
    w.is_control = ctl;
    w.bytes_written = SIZE_W'($urandom);
    return w;
  endfunction

  function automatic word_t prog(int unsigned n);
    word_t w;
    w.command = CMD_PROGRESS;
    w.msg_size = SIZE_W'($urandom);
    w.is_control = 1'($urandom_range(0, 1));
    w.bytes_written = n[SIZE_W-1:0];
    return w;
  endfunction

  // random word, mostly small sizes so budgets bite
  function automatic word_t rand_word();
    int unsigned sz, n;
    if ($urandom_range(0, 99) < 55) begin
      case ($urandom_range(0, 9))
        0: sz = $urandom_range(0, 24'hFFFFFF);
        1: sz = 0;
        default: sz = $urandom_range(1, 400);
      endcase
      return enq(sz, $urandom_range(0, 9) < 2);
    end
    case ($urandom_range(0, 7))
      0: n = $urandom_range(0, 24'hFFFFFF);
      1: n = 24'hFFFFFF;
      default: n = $urandom_range(0, 300);
    endcase
    return prog(n);
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (3 + 2 * QDEPTH + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [BYTE_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_BYTE_BUDGET) byte_budget_m = val;
    else msg_budget_m = val[MB_W-1:0];
  endtask

  task automatic run_phase(logic [BYTE_W-1:0] bb, logic [MB_W-1:0] mb, int n);
    wait_drained();
    write_reg(CFG_BYTE_BUDGET, bb);
    write_reg(CFG_MSG_BUDGET, BYTE_W'(mb));
    for (int i = 0; i < n; i++) queue_word(rand_word());
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_status.insert(expected_status.size(), queue_step(pending_words[0]));
        pending_words.delete(0);
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end else if (gap > 0) begin
        gap--;
      end
      if (pending_words.size() != 0 && gap == 0 && !hold_sender) begin
        in_valid         <= 1'b1;
        in_command       <= pending_words[0].command;
        in_msg_size      <= pending_words[0].msg_size;
        in_is_control    <= pending_words[0].is_control;
        in_bytes_written <= pending_words[0].bytes_written;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    status_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result word", $time);
          errors++;
        end else begin
          e = expected_status[0];
          expected_status.delete(0);
          if ({out_accepted, out_refused_full, out_dropped_now, out_front_completed,
               out_entry_count, out_bytes_queued, out_total_dropped, out_total_sent} !==
              {e.accepted, e.refused_full, e.dropped_now, e.front_completed,
               e.entry_count, e.bytes_queued, e.total_dropped, e.total_sent}) begin
            $display({"%0t: mismatch exp acc=%0d ref=%0d drop=%0d done=%0d",
                      " cnt=%0d bytes=%0d tdrop=%0d tsent=%0d"},
                     $time, e.accepted, e.refused_full, e.dropped_now, e.front_completed,
                     e.entry_count, e.bytes_queued, e.total_dropped, e.total_sent);
            $display({"%0t:          act acc=%0d ref=%0d drop=%0d done=%0d",
                      " cnt=%0d bytes=%0d tdrop=%0d tsent=%0d"},
                     $time, out_accepted, out_refused_full, out_dropped_now,
                     out_front_completed, out_entry_count, out_bytes_queued,
                     out_total_dropped, out_total_sent);
            errors++;
          end
        end
        stall = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    count_m = 0;
    bytes_m = '0;
    front_sent_m = '0;
    dropped_m = '0;
    sent_m = '0;
    byte_budget_m = BYTE_BUDGET_RST;
    msg_budget_m = MSG_BUDGET_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset budgets, extremes and corner cases
    queue_word(prog(5));
    queue_word(enq(0, 0));
    queue_word(prog(0));
    queue_word(enq(24'hFFFFFF, 0));
    queue_word(enq(24'hFFFFFF, 1));
    queue_word(enq(24'h3FFFFF, 0));
    queue_word(prog(24'hFFFFFF));
    queue_word(prog(1));
    queue_word(prog(24'hFFFFFF));
    for (int i = 0; i < 17; i++) queue_word(enq(100, 1));
    // pause the sender until everything has drained
    while (pending_words.size() != 0) @(posedge clk);
    hold_sender = 1'b1;
    wait_drained();
    hold_sender = 1'b0;
    queue_word(enq(5, 0));
    for (int i = 0; i < 17; i++) queue_word(prog(24'hFFFFFF));

    // phases across budget settings, extremes included
    run_phase(28'hFFFFFFF, 5'd31, 250);
    run_phase(28'd1, 5'd1, 200);
    run_phase(28'd600, 5'd4, 300);
    run_phase(28'd2000, 5'd0, 200);
    run_phase(28'd1500, 5'd16, 350);
    run_phase(28'd300, 5'd8, 250);
    run_phase(28'hFFFFFFF, 5'd17, 250);

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/doq_pkg.sv
design/doq_mem.sv
design/drop_oldest_message_queue_core.sv
tb/sv/drop_oldest_message_queue_core_tb.sv
